>>> hw/rtl/fpfa_pkg.sv
// ----------------------------------------------------------------------------
// fpfa_pkg: shared types and constants of the partition fit allocator
// Table sizes, field widths, policy and register codes, and the structs that
// move between the scan sequencer and the fit unit.
// ----------------------------------------------------------------------------
package fpfa_pkg;

  // Table geometry
  localparam int MaxPartitions  = 256;
  localparam int SizeBits       = 16;
  localparam int IdxBits        = $clog2(MaxPartitions);
  localparam int CountBits      = $clog2(MaxPartitions + 1);

  // Beat field widths
  localparam int IndexFieldBits = 8;
  localparam int PolicyBits     = 2;
  localparam int CfgIdxBits     = 2;
  localparam int CfgDataBits    = CountBits;

  typedef enum logic [PolicyBits-1:0] {
    FIT_FIRST  = 2'd0,
    FIT_BEST   = 2'd1,
    FIT_WORST  = 2'd2,
    FIT_REFUSE = 2'd3
  } fit_policy_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_FIT_POLICY      = 2'd0,
    CFG_PARTITION_COUNT = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_REQUEST = 1'b1
  } action_e;

  // One table entry as it leaves the read stage
  typedef struct packed {
    logic                valid;
    logic                used;
    logic [IdxBits-1:0]  index;
    logic [SizeBits-1:0] size;
  } fit_cand_t;

  // Current winner of the scan
  typedef struct packed {
    logic                found;
    logic [IdxBits-1:0]  index;
    logic [SizeBits-1:0] size;
  } fit_pick_t;

endpackage

>>> hw/rtl/fpfa_if.sv
// ----------------------------------------------------------------------------
// fpfa_if: valid/ready channels of the partition fit allocator
// Item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface fpfa_item_if;
  import fpfa_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [IndexFieldBits-1:0] partition_index;
  logic [SizeBits-1:0]       size;

  modport source (output valid, action, partition_index, size, input ready);
  modport sink   (input valid, action, partition_index, size, output ready);
endinterface

interface fpfa_result_if;
  import fpfa_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      granted;
  logic [IndexFieldBits-1:0] chosen_index;
  logic [SizeBits-1:0]       chosen_size;

  modport source (output valid, granted, chosen_index, chosen_size, input ready);
  modport sink   (input valid, granted, chosen_index, chosen_size, output ready);
endinterface

interface fpfa_cfg_if;
  import fpfa_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CfgIdxBits-1:0]  index;
  logic [CfgDataBits-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/fixed_partition_fit_allocator_top.sv
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_top: fixed partition fit allocator
// Keeps a table of partition sizes and used marks, loads entries and serves
// allocation requests by first, best or worst fit.
// ----------------------------------------------------------------------------
// A load beat writes the partition size and clears its used mark. A request
// beat keeps the block busy through a scan of min(partition_count, 256)
// entries and the commit. The table is scanned one entry per cycle through
// the size memory's single read port into one shared compare unit. After the
// scan, the read stage drains, the sequencer hands over to the commit state
// and that state commits the winner. No new beat is taken during a scan. One
// result is buffered, so the next beat is taken while a result waits; a
// commit waits for that buffer to drain. Configuration is always ready; it is
// to be written only while the block is idle, which the block itself does not
// enforce. There is no clearing pass after reset.
module fixed_partition_fit_allocator_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  fpfa_item_if.sink     item_i,
  fpfa_result_if.source result_o,
  fpfa_cfg_if.sink      cfg_i
);
  import fpfa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  fit_policy_e            policy_q;
  logic [CountBits-1:0]   count_q;
  logic [CountBits-1:0]   count_eff;
  logic [CountBits-1:0]   addr_q;
  logic [SizeBits-1:0]    want_q;
  logic [MaxPartitions-1:0] used_q;
  logic [SizeBits-1:0]    size_mem [MaxPartitions];
  logic [SizeBits-1:0]    rd_size_q;
  logic                   rd_vld_q;
  logic                   rd_used_q;
  logic [IdxBits-1:0]     rd_idx_q;
  logic                   res_valid_q;
  logic                   res_granted_q;
  logic [IndexFieldBits-1:0] res_index_q;
  logic [SizeBits-1:0]    res_size_q;
  logic                   item_fire;
  logic                   load_fire;
  logic                   req_fire;
  logic                   load_in_range;
  logic                   issue;
  logic                   commit;
  fit_cand_t              cand;
  fit_pick_t              pick;

  // Handshake decode
  assign item_i.ready  = (state_q == S_IDLE);
  assign item_fire     = item_i.valid && item_i.ready;
  assign load_fire     = item_fire && (action_e'(item_i.action) == ACT_LOAD);
  assign req_fire      = item_fire && (action_e'(item_i.action) == ACT_REQUEST);
  assign load_in_range = (32'(item_i.partition_index) < MaxPartitions);
  assign cfg_i.ready   = 1'b1;

  // Clamp the scan length to the table
  assign count_eff = (count_q > CountBits'(MaxPartitions)) ?
                     CountBits'(MaxPartitions) : count_q;
  assign issue     = (state_q == S_SCAN) && (addr_q < count_eff);
  assign commit    = (state_q == S_COMMIT) && (!res_valid_q || result_o.ready);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (req_fire) state_d = S_SCAN;
      S_SCAN:   if (!issue && !rd_vld_q) state_d = S_COMMIT;
      S_COMMIT: if (commit) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Size memory: write on load, read one entry per scan cycle
  always_ff @(posedge clk_i) begin
    if (load_fire && load_in_range) begin
      size_mem[IdxBits'(item_i.partition_index)] <= item_i.size;
    end
    if (issue) begin
      rd_size_q <= size_mem[addr_q[IdxBits-1:0]];
    end
  end

  // Request payload and read stage tags
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      want_q <= item_i.size;
    end
    rd_idx_q  <= addr_q[IdxBits-1:0];
    rd_used_q <= used_q[addr_q[IdxBits-1:0]];
  end

  // Sequencer, registers and used marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      policy_q <= FIT_FIRST;
      count_q  <= '0;
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
      used_q   <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (cfg_i.valid) begin
        unique case (cfg_reg_e'(cfg_i.index))
          CFG_FIT_POLICY:      policy_q <= fit_policy_e'(cfg_i.data[PolicyBits-1:0]);
          CFG_PARTITION_COUNT: count_q  <= cfg_i.data;
          default: ;
        endcase
      end
      if (req_fire) begin
        addr_q <= '0;
      end else if (issue) begin
        addr_q <= addr_q + 1'b1;
      end
      if (load_fire && load_in_range) begin
        used_q[IdxBits'(item_i.partition_index)] <= 1'b0;
      end
      if (commit && pick.found) begin
        used_q[pick.index] <= 1'b1;
      end
    end
  end

  // Feed the compare unit
  assign cand.valid = rd_vld_q;
  assign cand.used  = rd_used_q;
  assign cand.index = rd_idx_q;
  assign cand.size  = rd_size_q;

  fpfa_fit_unit u_fit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (req_fire),
    .policy_i (policy_q),
    .want_i   (want_q),
    .cand_i   (cand),
    .pick_o   (pick)
  );

  // Result buffer: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (commit) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      res_granted_q <= pick.found;
      res_index_q   <= pick.found ? IndexFieldBits'(pick.index) : '0;
      res_size_q    <= pick.found ? pick.size : '0;
    end
  end

  assign result_o.valid        = res_valid_q;
  assign result_o.granted      = res_granted_q;
  assign result_o.chosen_index = res_index_q;
  assign result_o.chosen_size  = res_size_q;

  // A granted partition is marked used right after the commit
  a_mark_on_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && pick.found) |=> used_q[$past(pick.index)])
    else $error("granted partition not marked used");

  // A refusal carries zero index and size
  a_refusal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.granted) |->
      (result_o.chosen_index == '0 && result_o.chosen_size == '0))
    else $error("refusal with nonzero fields");

  // Read stage is busy only during a scan
  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == S_SCAN))
    else $error("read stage active outside a scan");

  // The scan address never runs past the partition count
  a_addr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (addr_q <= count_eff))
    else $error("scan address beyond partition count");

endmodule

>>> hw/rtl/fpfa_fit_unit.sv
// ----------------------------------------------------------------------------
// fpfa_fit_unit: shared compare unit of the partition scan
// Takes one table entry per cycle, checks it against the request and the
// current winner under the active policy, and keeps the winner.
// ----------------------------------------------------------------------------
module fpfa_fit_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  fpfa_pkg::fit_policy_e         policy_i,
  input  logic [fpfa_pkg::SizeBits-1:0] want_i,
  input  fpfa_pkg::fit_cand_t           cand_i,
  output fpfa_pkg::fit_pick_t           pick_o
);
  import fpfa_pkg::*;

  fit_pick_t pick_q;
  logic      eligible;
  logic      better;
  logic      take;

  // Entry is free and large enough
  assign eligible = cand_i.valid && !cand_i.used && (cand_i.size >= want_i);

  // Rank the entry against the winner; ties go to the later index
  always_comb begin
    unique case (policy_i)
      FIT_FIRST: better = !pick_q.found;
      FIT_BEST:  better = !pick_q.found || (cand_i.size <= pick_q.size);
      FIT_WORST: better = !pick_q.found || (cand_i.size >= pick_q.size);
      default:   better = 1'b0;
    endcase
  end

  assign take = eligible && better;

  // Hold the winner; drop it when a new scan starts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_q <= '0;
    end else if (start_i) begin
      pick_q.found <= 1'b0;
    end else if (take) begin
      pick_q.found <= 1'b1;
      pick_q.index <= cand_i.index;
      pick_q.size  <= cand_i.size;
    end
  end

  assign pick_o = pick_q;

  // A winner always satisfies the request
  a_pick_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pick_q.found |-> (pick_q.size >= want_i))
    else $error("fit unit holds a partition smaller than the request");

  // A new scan starts with no winner
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> !pick_q.found)
    else $error("winner survived the start of a scan");

  // First fit never replaces its winner
  a_first_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pick_q.found && policy_i == FIT_FIRST && !start_i) |=> $stable(pick_q))
    else $error("first fit replaced its winner");

endmodule
